/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define JAR_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("assertion failed");

// Same, on the block clock and reset.
`define JAR_ASSERT_CLK(lbl, prop) `JAR_ASSERT(lbl, clk, arst_n, prop)

`endif

/* rtl/jar_pkg.sv */
// Types, register indexes and reset values for the joystick autorepeat qualifier.
package jar_pkg;

	localparam int LOCKOUT_COMMANDS = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	typedef enum logic [3:0] {
		CMD_NONE    = 4'd0,
		CMD_ROT_CW  = 4'd1,
		CMD_ROT_CCW = 4'd2,
		CMD_LEFT    = 4'd3,
		CMD_RIGHT   = 4'd4,
		CMD_DOWN    = 4'd5,
		CMD_DROP    = 4'd6,
		CMD_GRAVITY = 4'd7,
		CMD_PAUSE   = 4'd8
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] CFG_FALL_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_MINIMUM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_IVL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TIMEOUT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_LONG  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_SHORT = 3'd6;

	localparam logic [7:0]  RST_FALL_PERIOD   = 8'd200;
	localparam logic [7:0]  RST_GLIDE_MINIMUM = 8'd75;
	localparam logic [6:0]  RST_REPEAT_DELAY  = 7'd40;
	localparam logic [6:0]  RST_REPEAT_IVL    = 7'd10;
	localparam logic [13:0] RST_PAUSE_TIMEOUT = 14'd12000;
	localparam logic [4:0]  RST_LOCKOUT_LONG  = 5'd24;
	localparam logic [4:0]  RST_LOCKOUT_SHORT = 5'd12;

	// Lockout slot k belongs to command k+1; true where the short lockout applies.
	function automatic logic slot_is_short(input int k);
		return (k == int'(CMD_LEFT) - 1) || (k == int'(CMD_RIGHT) - 1) ||
			(k == int'(CMD_DOWN) - 1);
	endfunction

endpackage

/* rtl/joystick_autorepeat_qualifier.sv */
// Joystick autorepeat qualifier: one command per button poll tick.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one poll tick per beat: five
//    buttons plus the gliding flag. Output channel (out_valid/out_ready)
//    returns exactly one command per input beat, in order.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//    seven timing registers; cfg_ready is always high, unknown indexes are
//    dropped. Write only while no tick is in flight.
//  - Output: the command is registered and shown in the cycle after its tick is accepted.
//  - Throughput: one tick per cycle unless stalled; all qualification is
//    one pass of logic from the state registers into the output register.
//  - Stall: while the output register holds an untaken command, a new tick
//    is accepted only in the cycle the receiver takes the old one
//    (in_ready = !out_valid || out_ready).
//  - Reset (arst_n low, asynchronous): registers return to their reset
//    values, fall, pause and lockout counters clear, the repeat counter
//    reloads with minus the first delay, output goes empty.
module joystick_autorepeat_qualifier import jar_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  btn_fire,
	input  logic                  btn_left,
	input  logic                  btn_right,
	input  logic                  btn_up,
	input  logic                  btn_down,
	input  logic                  gliding,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [3:0]            command
);

	logic [7:0]  fall_period_q, glide_minimum_q;
	logic [6:0]  repeat_delay_q, repeat_ivl_q;
	logic [13:0] pause_timeout_q;
	logic [4:0]  lockout_long_q, lockout_short_q;

	cmd_t        last_cmd_q, last_cmd_n;
	logic [7:0]  fall_ticks_q, fall_ticks_n;
	logic [7:0]  repeat_q, repeat_n;
	logic [13:0] pause_ticks_q, pause_ticks_n;
	logic [4:0]  lock_q [LOCKOUT_COMMANDS];
	logic [4:0]  lock_n [LOCKOUT_COMMANDS];

	logic        out_valid_q;
	cmd_t        command_q;

	logic        in_acc;
	logic [7:0]  period;
	logic [7:0]  repeat_reload;
	logic [14:0] pause_next;
	cmd_t        joy, res;
	logic        locked;
	logic [LOCKOUT_COMMANDS-1:0] arm;
	logic [2:0]  joy_slot;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign command   = command_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_period_q   <= RST_FALL_PERIOD;
			glide_minimum_q <= RST_GLIDE_MINIMUM;
			repeat_delay_q  <= RST_REPEAT_DELAY;
			repeat_ivl_q    <= RST_REPEAT_IVL;
			pause_timeout_q <= RST_PAUSE_TIMEOUT;
			lockout_long_q  <= RST_LOCKOUT_LONG;
			lockout_short_q <= RST_LOCKOUT_SHORT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FALL_PERIOD:   fall_period_q   <= cfg_data[7:0];
				CFG_GLIDE_MINIMUM: glide_minimum_q <= cfg_data[7:0];
				CFG_REPEAT_DELAY:  repeat_delay_q  <= cfg_data[6:0];
				CFG_REPEAT_IVL:    repeat_ivl_q    <= cfg_data[6:0];
				CFG_PAUSE_TIMEOUT: pause_timeout_q <= cfg_data;
				CFG_LOCKOUT_LONG:  lockout_long_q  <= cfg_data[4:0];
				CFG_LOCKOUT_SHORT: lockout_short_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Button priority: fire, left, right, up+down, down, up.
	always_comb begin
		if (btn_fire)                  joy = CMD_DROP;
		else if (btn_left)             joy = CMD_LEFT;
		else if (btn_right)            joy = CMD_RIGHT;
		else if (btn_up && btn_down)   joy = CMD_PAUSE;
		else if (btn_down)             joy = CMD_DOWN;
		else if (btn_up)               joy = CMD_ROT_CW;
		else                           joy = CMD_NONE;
	end

	assign period = (gliding && fall_period_q < glide_minimum_q) ? glide_minimum_q
		: fall_period_q;
	assign repeat_reload = 8'd0 - {1'b0, repeat_delay_q};
	assign pause_next    = {1'b0, pause_ticks_q} + 15'd1;
	assign joy_slot      = 3'(joy - CMD_ROT_CW);

	always_comb begin
		locked = 1'b0;
		if (joy >= CMD_ROT_CW && joy <= CMD_DROP)
			locked = lock_q[joy_slot] != 5'd0;
	end

	always_comb begin
		last_cmd_n    = last_cmd_q;
		fall_ticks_n  = fall_ticks_q;
		repeat_n      = repeat_q;
		pause_ticks_n = pause_ticks_q;
		res           = CMD_NONE;
		arm           = '0;
		for (int k = 0; k < LOCKOUT_COMMANDS; k++)
			lock_n[k] = lock_q[k];

		if (fall_ticks_q >= period) begin
			// gravity tick: sample ignored, nothing else moves
			fall_ticks_n = 8'd0;
			res          = CMD_GRAVITY;
		end else begin
			if (locked) begin
				last_cmd_n = CMD_NONE;
			end else if (joy == CMD_LEFT || joy == CMD_RIGHT || joy == CMD_DOWN) begin
				if (last_cmd_q != joy) begin
					repeat_n   = repeat_reload;
					last_cmd_n = joy;
					res        = joy;
				end else if ($signed(repeat_q) >= $signed({1'b0, repeat_ivl_q})) begin
					repeat_n = 8'd0;
					res      = joy;
				end else if ($signed(repeat_q) < 8'sd127) begin
					repeat_n = repeat_q + 8'd1;
				end
			end else if (joy == CMD_DROP || joy == CMD_ROT_CW) begin
				if (last_cmd_q != joy) begin
					last_cmd_n = joy;
					res        = joy;
				end
			end else if (joy == CMD_PAUSE) begin
				if (lock_q[int'(CMD_ROT_CW) - 1] == 5'd0 &&
					lock_q[int'(CMD_DOWN) - 1] == 5'd0) begin
					arm[int'(CMD_ROT_CW) - 1] = 1'b1;
					arm[int'(CMD_DOWN) - 1]   = 1'b1;
					last_cmd_n    = CMD_PAUSE;
					res           = CMD_PAUSE;
					pause_ticks_n = 14'd0;
				end else begin
					last_cmd_n = CMD_NONE;
				end
			end else begin
				// release: lock out the command just let go
				for (int k = 0; k < LOCKOUT_COMMANDS; k++)
					if (int'(last_cmd_q) == k + 1)
						arm[k] = 1'b1;
				if (last_cmd_q != CMD_PAUSE) begin
					last_cmd_n = CMD_NONE;
				end else begin
					pause_ticks_n = pause_next[14] ? 14'h3fff : pause_next[13:0];
					if (pause_next > {1'b0, pause_timeout_q})
						last_cmd_n = CMD_NONE;
				end
				repeat_n = repeat_reload;
			end

			// arm only an idle slot, then every slot counts down
			for (int k = 0; k < LOCKOUT_COMMANDS; k++) begin
				if (arm[k] && lock_q[k] == 5'd0)
					lock_n[k] = slot_is_short(k) ? lockout_short_q : lockout_long_q;
				if (lock_n[k] != 5'd0)
					lock_n[k] = lock_n[k] - 5'd1;
			end

			if (res == CMD_DOWN || res == CMD_DROP) begin
				fall_ticks_n = 8'd0;
			end else if (res != CMD_PAUSE &&
				!(res == CMD_NONE && last_cmd_n == CMD_PAUSE)) begin
				if (fall_ticks_q != 8'hff)
					fall_ticks_n = fall_ticks_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q    <= CMD_NONE;
			fall_ticks_q  <= 8'd0;
			repeat_q      <= 8'd0 - {1'b0, RST_REPEAT_DELAY};
			pause_ticks_q <= 14'd0;
			for (int k = 0; k < LOCKOUT_COMMANDS; k++)
				lock_q[k] <= 5'd0;
		end else if (in_acc) begin
			last_cmd_q    <= last_cmd_n;
			fall_ticks_q  <= fall_ticks_n;
			repeat_q      <= repeat_n;
			pause_ticks_q <= pause_ticks_n;
			for (int k = 0; k < LOCKOUT_COMMANDS; k++)
				lock_q[k] <= lock_n[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			command_q <= res;
	end

endmodule

/* rtl/jar_checker.sv */
// Port-level checker for the joystick autorepeat qualifier, bound to the top level.
`include "assert_macros.svh"

module jar_checker import jar_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [3:0]            command
);

	// a stalled result holds
	`JAR_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(command))

	// an accepted beat always shows a result next cycle
	`JAR_ASSERT_CLK(a_in_to_out, in_valid && in_ready |=> out_valid)

	// no new beat while a result waits and the receiver stalls
	`JAR_ASSERT_CLK(a_no_overrun, out_valid && !out_ready |-> !in_ready)

	// empty output never blocks the input
	`JAR_ASSERT_CLK(a_ready_empty, !out_valid |-> in_ready)

	// a shown command is a defined code and never rotate counterclockwise
	`JAR_ASSERT_CLK(a_cmd_code,
		out_valid |-> command <= CMD_PAUSE && command != CMD_ROT_CCW)

endmodule

bind joystick_autorepeat_qualifier jar_checker u_jar_checker (.*);
